// ===== design/rws_pkg.sv =====
// shared constants, codes and types of the retransmit window scheduler
`timescale 1ns / 1ps
`default_nettype none
package rws_pkg;

  localparam int DEPTH       = 16;
  localparam int BACKOFF_CAP = 10;

  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SEQ_W      = 32;
  localparam int TIME_W     = 32;
  localparam int RETRY_W    = 8;
  localparam int RTO_W      = 16;
  localparam int ELAPSED_W  = 16;
  localparam int WLIM_W     = 5;
  localparam int KIND_W     = 3;
  localparam int CMD_W      = 2;
  localparam int TOTAL_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SH_W       = $clog2(BACKOFF_CAP + 1) > 0 ? $clog2(BACKOFF_CAP + 1) : 1;
  localparam int TO_W       = RTO_W + BACKOFF_CAP;
  localparam int CMP_W      = (TO_W > TIME_W) ? TO_W : TIME_W;

  // reset values of the configuration registers
  localparam logic [RTO_W-1:0]   RTO_RESET  = RTO_W'(1000);
  localparam logic [RETRY_W-1:0] MAXR_RESET = RETRY_W'(5);
  localparam logic [WLIM_W-1:0]  WLIM_RESET = WLIM_W'(16);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RTO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAXR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WLIM = 2'd2;

  // commands
  localparam logic [CMD_W-1:0] CMD_QUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACK_HIT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ACK_MISS = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RETX     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_GIVEUP   = 3'd5;

  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [TIME_W-1:0]  sent;
    logic [RETRY_W-1:0] retries;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SEQ_W-1:0]   seq;
    logic [RETRY_W-1:0] retry;
    logic [TOTAL_W-1:0] total;
  } res_t;

  typedef struct packed {
    logic load;       // latch a new item, start the sweep
    logic queue_go;   // finish a queue item
    logic advance;    // retire the entry under the sweep
    logic finish_go;  // send the closing result
  } ctl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             scan_done;
    logic             emit_hit;
    logic             pend_valid;
    logic             out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== design/rws_if.sv =====
// handshake channels of the retransmit window scheduler
`timescale 1ns / 1ps
`default_nettype none
interface rws_item_if;
  logic                         valid;
  logic                         ready;
  logic [rws_pkg::CMD_W-1:0]     cmd;
  logic [rws_pkg::SEQ_W-1:0]     ack_seq;
  logic [rws_pkg::ELAPSED_W-1:0] elapsed_ms;

  modport source (output valid, cmd, ack_seq, elapsed_ms, input ready);
  modport sink (input valid, cmd, ack_seq, elapsed_ms, output ready);
endinterface

interface rws_result_if;
  logic                       valid;
  logic                       ready;
  logic [rws_pkg::KIND_W-1:0]  kind;
  logic [rws_pkg::SEQ_W-1:0]   seq_out;
  logic [rws_pkg::RETRY_W-1:0] retry_count;
  logic [rws_pkg::TOTAL_W-1:0] pending_total;
  logic                       last;

  modport source (output valid, kind, seq_out, retry_count, pending_total, last,
                  input ready);
  modport sink (input valid, kind, seq_out, retry_count, pending_total, last,
                output ready);
endinterface

interface rws_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rws_pkg::CFG_IDX_W-1:0]  index;
  logic [rws_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/retransmit_window_scheduler.sv =====
// top level of the retransmit window scheduler
// a queue beat gives its result through the queue state and the output register; an ack
// or tick beat sweeps the table one entry per cycle while no held result waits on the result
// side, with n pending entries (at most 16); an ack gives one result, a tick one per
// retransmit or give-up and none if nothing expired; one beat is taken at a time
// reset: 1000 ms / 5 retries / 16 entries, window empty, sequence 1, clock 0, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module retransmit_window_scheduler (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rws_item_if.sink   item_i,
  rws_result_if.source result_o,
  rws_cfg_if.sink    cfg_i
);

  rws_pkg::ctl_cmd_t   ctl;
  rws_pkg::dp_status_t st;
  rws_pkg::res_t       res;
  logic                item_ready;

  assign item_i.ready = item_ready;
  assign cfg_i.ready  = 1'b1;

  rws_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_cmd_i   (item_i.cmd),
    .item_ready_o (item_ready),
    .st_i         (st),
    .ctl_o        (ctl)
  );

  rws_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .st_o              (st),
    .item_cmd_i        (item_i.cmd),
    .item_ack_seq_i    (item_i.ack_seq),
    .item_elapsed_ms_i (item_i.elapsed_ms),
    .cfg_we_i          (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .out_ready_i       (result_o.ready),
    .out_valid_o       (result_o.valid),
    .out_res_o         (res),
    .out_last_o        (result_o.last)
  );

  assign result_o.kind          = res.kind;
  assign result_o.seq_out       = res.seq;
  assign result_o.retry_count   = res.retry;
  assign result_o.pending_total = res.total;

endmodule
`default_nettype wire

// ===== design/rws_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module rws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== design/rws_ctrl.sv =====
// sequencer of the retransmit window scheduler
`timescale 1ns / 1ps
`default_nettype none
module rws_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                item_valid_i,
  input  wire logic [rws_pkg::CMD_W-1:0] item_cmd_i,
  output logic                     item_ready_o,
  input  wire rws_pkg::dp_status_t st_i,
  output rws_pkg::ctl_cmd_t        ctl_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_QUEUE  = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign item_ready_o = (state_q == S_IDLE);
  assign accept       = item_valid_i && item_ready_o;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctl_o.load = 1'b1;
          case (item_cmd_i)
            rws_pkg::CMD_QUEUE: state_d = S_QUEUE;
            rws_pkg::CMD_ACK,
            rws_pkg::CMD_TICK:  state_d = S_SCAN;
            default:            state_d = S_IDLE;
          endcase
        end
      end
      S_QUEUE: begin
        if (st_i.out_free) begin
          ctl_o.queue_go = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SCAN: begin
        if (st_i.scan_done) begin
          state_d = S_FINISH;
        end else if (!(st_i.emit_hit && st_i.pend_valid && !st_i.out_free)) begin
          // a second result needs the held one pushed out first
          ctl_o.advance = 1'b1;
        end
      end
      S_FINISH: begin
        if (st_i.cmd == rws_pkg::CMD_TICK && !st_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (st_i.out_free) begin
          ctl_o.finish_go = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/rws_datapath.sv =====
// window table, timers, result hold stage and output register
`timescale 1ns / 1ps
`default_nettype none
module rws_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire rws_pkg::ctl_cmd_t                   ctl_i,
  output rws_pkg::dp_status_t                      st_o,
  input  wire logic [rws_pkg::CMD_W-1:0]           item_cmd_i,
  input  wire logic [rws_pkg::SEQ_W-1:0]           item_ack_seq_i,
  input  wire logic [rws_pkg::ELAPSED_W-1:0]       item_elapsed_ms_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [rws_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [rws_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output rws_pkg::res_t                            out_res_o,
  output logic                                     out_last_o
);

  // configuration
  logic [rws_pkg::RTO_W-1:0]   rto_q;
  logic [rws_pkg::RETRY_W-1:0] maxr_q;
  logic [rws_pkg::WLIM_W-1:0]  wlim_q;

  // block state
  logic [rws_pkg::SEQ_W-1:0]  next_seq_q;
  logic [rws_pkg::TIME_W-1:0] clock_q;
  logic [rws_pkg::CNT_W-1:0]  cnt_q;

  // sweep state
  logic [rws_pkg::CMD_W-1:0] cmd_q;
  logic [rws_pkg::SEQ_W-1:0] ack_q;
  logic [rws_pkg::CNT_W-1:0] r_q, r_d, w_q, end_q;
  logic                      found_q;

  // hold stage and output register
  logic          pend_valid_q;
  rws_pkg::res_t pend_q;
  logic          out_valid_q;
  rws_pkg::res_t out_q;
  logic          out_last_q;

  logic                          ram_we;
  logic [rws_pkg::IDX_W-1:0]     ram_waddr;
  rws_pkg::entry_t               ram_wdata;
  logic [$bits(rws_pkg::entry_t)-1:0] ram_rdata;
  rws_pkg::entry_t               rd;
  rws_pkg::entry_t               upd;

  logic [rws_pkg::TIME_W-1:0] age;
  logic [rws_pkg::SH_W-1:0]   sh;
  logic                       expired, give_up, ack_hit, emit_hit, drop, full, out_free;
  logic                       is_tick, is_ack;
  rws_pkg::res_t              scan_res, queue_res, ack_res;
  logic [rws_pkg::SEQ_W-1:0]  seq_inc;

  rws_ram #(
    .WIDTH ($bits(rws_pkg::entry_t)),
    .DEPTH (rws_pkg::DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (r_d[rws_pkg::IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd      = rws_pkg::entry_t'(ram_rdata);
  assign is_tick = (cmd_q == rws_pkg::CMD_TICK);
  assign is_ack  = (cmd_q == rws_pkg::CMD_ACK);

  // timeout check of the entry under the sweep
  assign age = clock_q - rd.sent;
  assign sh  = (rd.retries < rws_pkg::RETRY_W'(rws_pkg::BACKOFF_CAP))
             ? rws_pkg::SH_W'(rd.retries) : rws_pkg::SH_W'(rws_pkg::BACKOFF_CAP);
  assign expired  = rws_pkg::CMP_W'(age) >= (rws_pkg::CMP_W'(rto_q) << sh);
  assign give_up  = (rd.retries >= maxr_q);
  assign ack_hit  = is_ack && !found_q && (rd.seq == ack_q);
  assign emit_hit = is_tick && expired;
  assign drop     = ack_hit || (emit_hit && give_up);

  always_comb begin
    upd = rd;
    if (emit_hit && !give_up) begin
      upd.sent    = clock_q;
      upd.retries = (rd.retries == '1) ? rd.retries : rd.retries + 1'b1;
    end
  end

  always_comb begin
    scan_res.kind  = give_up ? rws_pkg::KIND_GIVEUP : rws_pkg::KIND_RETX;
    scan_res.seq   = rd.seq;
    scan_res.retry = upd.retries;
    scan_res.total = give_up ? rws_pkg::TOTAL_W'(cnt_q - 1'b1) : rws_pkg::TOTAL_W'(cnt_q);
    if (give_up) begin
      scan_res.retry = rd.retries;
    end
  end

  // cnt never exceeds the depth, so this is cnt >= min(limit, depth)
  assign full = (32'(cnt_q) >= 32'(wlim_q)) || (32'(cnt_q) >= rws_pkg::DEPTH);

  always_comb begin
    queue_res.kind  = full ? rws_pkg::KIND_FULL : rws_pkg::KIND_ACCEPTED;
    queue_res.seq   = full ? '0 : next_seq_q;
    queue_res.retry = '0;
    queue_res.total = full ? rws_pkg::TOTAL_W'(cnt_q) : rws_pkg::TOTAL_W'(cnt_q + 1'b1);
    ack_res.kind    = found_q ? rws_pkg::KIND_ACK_HIT : rws_pkg::KIND_ACK_MISS;
    ack_res.seq     = ack_q;
    ack_res.retry   = '0;
    ack_res.total   = rws_pkg::TOTAL_W'(cnt_q);
  end

  assign seq_inc = (next_seq_q + 1'b1 == '0) ? rws_pkg::SEQ_W'(1) : next_seq_q + 1'b1;

  // table writes: a new entry at the end, or a kept entry compacted down
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w_q[rws_pkg::IDX_W-1:0];
    ram_wdata = upd;
    if (ctl_i.queue_go && !full) begin
      ram_we            = 1'b1;
      ram_waddr         = cnt_q[rws_pkg::IDX_W-1:0];
      ram_wdata.seq     = next_seq_q;
      ram_wdata.sent    = clock_q;
      ram_wdata.retries = '0;
    end else if (ctl_i.advance && !drop) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    r_d = r_q;
    if (ctl_i.load) begin
      r_d = '0;
    end else if (ctl_i.advance) begin
      r_d = r_q + 1'b1;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  assign st_o.cmd        = cmd_q;
  assign st_o.scan_done  = (r_q == end_q);
  assign st_o.emit_hit   = emit_hit;
  assign st_o.pend_valid = pend_valid_q;
  assign st_o.out_free   = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rto_q        <= rws_pkg::RTO_RESET;
      maxr_q       <= rws_pkg::MAXR_RESET;
      wlim_q       <= rws_pkg::WLIM_RESET;
      next_seq_q   <= rws_pkg::SEQ_W'(1);
      clock_q      <= '0;
      cnt_q        <= '0;
      cmd_q        <= rws_pkg::CMD_NOP;
      r_q          <= '0;
      w_q          <= '0;
      end_q        <= '0;
      found_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          rws_pkg::REG_RTO:  rto_q  <= cfg_data_i[rws_pkg::RTO_W-1:0];
          rws_pkg::REG_MAXR: maxr_q <= cfg_data_i[rws_pkg::RETRY_W-1:0];
          rws_pkg::REG_WLIM: wlim_q <= cfg_data_i[rws_pkg::WLIM_W-1:0];
          default: ;
        endcase
      end

      r_q <= r_d;

      // a new beat is loaded only when the old one leaves or the register is empty
      if (ctl_i.queue_go || ctl_i.finish_go || (ctl_i.advance && emit_hit && pend_valid_q)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (ctl_i.load) begin
        cmd_q   <= item_cmd_i;
        w_q     <= '0;
        end_q   <= cnt_q;
        found_q <= 1'b0;
        if (item_cmd_i == rws_pkg::CMD_TICK) begin
          clock_q <= clock_q + rws_pkg::TIME_W'(item_elapsed_ms_i);
        end
      end

      if (ctl_i.queue_go) begin
        if (!full) begin
          cnt_q      <= cnt_q + 1'b1;
          next_seq_q <= seq_inc;
        end
      end

      if (ctl_i.advance) begin
        if (!drop) begin
          w_q <= w_q + 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
        if (ack_hit) begin
          found_q <= 1'b1;
        end
        if (emit_hit) begin
          pend_valid_q <= 1'b1;
        end
      end

      if (ctl_i.finish_go) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      ack_q <= item_ack_seq_i;
    end
    if (ctl_i.queue_go) begin
      out_q      <= queue_res;
      out_last_q <= 1'b1;
    end
    if (ctl_i.advance && emit_hit) begin
      pend_q <= scan_res;
      if (pend_valid_q) begin
        out_q      <= pend_q;
        out_last_q <= 1'b0;
      end
    end
    if (ctl_i.finish_go) begin
      out_q      <= is_ack ? ack_res : pend_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire
